/* rtl/mse_pkg.sv */
package mse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = CNT_W + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_push_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRIME = 4'b0010,
    S_MERGE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

/* rtl/mse_ram.sv */
module mse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a read of the entry being written returns the new data
  always_ff @(posedge clk) begin
    rdata0 <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
    rdata1 <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
  end

endmodule

/* rtl/mse_out_buf.sv */
module mse_out_buf
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  out_push_t  push,
  output logic [1:0] credit,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [1:0] count;
  out_item_t  head;
  out_item_t  spare;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_item  = head;
  assign pop       = out_valid && !out_stall;
  assign credit    = 2'd2 - count + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && pop) begin
      if (count == 2'd2) begin
        head  <= spare;
        spare <= push.item;
      end else begin
        head <= push.item;
      end
    end else if (pop) begin
      head <= spare;
    end else if (push.valid) begin
      if (count == 2'd0) begin
        head <= push.item;
      end else begin
        spare <= push.item;
      end
    end
  end

endmodule

/* rtl/mse_ctrl.sv */
module mse_ctrl
  import mse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  in_item_t                 in_item,
  output logic                     in_stall,
  output ram_wr_t                  wr_a,
  output ram_wr_t                  wr_b,
  output logic [ADDR_W-1:0]        raddr0,
  output logic [ADDR_W-1:0]        raddr1,
  input  logic signed [DATA_W-1:0] qa0,
  input  logic signed [DATA_W-1:0] qa1,
  input  logic signed [DATA_W-1:0] qb0,
  input  logic signed [DATA_W-1:0] qb1,
  input  logic [1:0]               credit,
  output out_push_t                push
);

  state_t            state;
  logic              src;
  logic [CNT_W-1:0]  cnt;
  logic              dropped;
  logic [CNT_W-1:0]  width;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  e;
  logic              pend;
  logic              pend_last;
  logic              pend_ovf;

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  n_after;
  logic signed [DATA_W-1:0] d0;
  logic signed [DATA_W-1:0] d1;
  logic              take_a;
  logic [CNT_W-1:0]  k1;
  logic              seg_done;
  logic              pass_done;
  logic              sort_done;
  logic [SUM_W-1:0]  w2;
  logic [CNT_W-1:0]  new_lo;
  logic [CNT_W-1:0]  new_w;
  logic [SUM_W-1:0]  mid_sum;
  logic [SUM_W-1:0]  hi_sum;
  logic [CNT_W-1:0]  mid_n;
  logic [CNT_W-1:0]  hi_n;
  logic [CNT_W-1:0]  i_m;
  logic [CNT_W-1:0]  j_m;
  logic              issue;
  logic              e_last;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign room     = (cnt < CNT_W'(MAX_ELEMENTS));
  assign n_after  = room ? cnt + CNT_W'(1) : cnt;

  assign d0 = src ? qb0 : qa0;
  assign d1 = src ? qb1 : qa1;

  // one merge step: pick the smaller head, or drain whichever run is left
  always_comb begin
    take_a    = (i < mid) && ((j >= hi) || (d0 < d1));
    k1        = k + CNT_W'(1);
    seg_done  = (k1 == hi);
    pass_done = seg_done && (hi == cnt);
    w2        = {1'b0, width} << 1;
    sort_done = pass_done && (w2 >= {1'b0, cnt});
    new_lo    = pass_done ? '0 : hi;
    new_w     = pass_done ? w2[CNT_W-1:0] : width;
    mid_sum   = {1'b0, new_lo} + {1'b0, new_w};
    hi_sum    = mid_sum + {1'b0, new_w};
    mid_n     = (mid_sum > {1'b0, cnt}) ? cnt : mid_sum[CNT_W-1:0];
    hi_n      = (hi_sum > {1'b0, cnt}) ? cnt : hi_sum[CNT_W-1:0];
    i_m       = seg_done ? new_lo : i + CNT_W'(take_a);
    j_m       = seg_done ? mid_n : j + CNT_W'(!take_a);
  end

  assign issue  = (state == S_EMIT) && (credit > {1'b0, pend});
  assign e_last = ((e + CNT_W'(1)) == cnt);

  // read the heads the merge will need next cycle, or in emit the next result
  always_comb begin
    unique case (state)
      S_MERGE: begin
        raddr0 = i_m[ADDR_W-1:0];
        raddr1 = j_m[ADDR_W-1:0];
      end
      S_EMIT: begin
        raddr0 = e[ADDR_W-1:0];
        raddr1 = j[ADDR_W-1:0];
      end
      default: begin
        raddr0 = i[ADDR_W-1:0];
        raddr1 = j[ADDR_W-1:0];
      end
    endcase
  end

  always_comb begin
    wr_a.we   = 1'b0;
    wr_a.addr = k[ADDR_W-1:0];
    wr_a.data = take_a ? d0 : d1;
    wr_b.we   = (state == S_MERGE) && !src;
    wr_b.addr = k[ADDR_W-1:0];
    wr_b.data = take_a ? d0 : d1;
    if (state == S_MERGE) begin
      wr_a.we = src;
    end else if (accept && room) begin
      wr_a.we   = 1'b1;
      wr_a.addr = cnt[ADDR_W-1:0];
      wr_a.data = in_item.value;
    end
  end

  always_comb begin
    push.valid          = pend;
    push.item.value_res = d0;
    push.item.last_res  = pend_last;
    push.item.overflow  = pend_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      src     <= 1'b0;
      cnt     <= '0;
      dropped <= 1'b0;
      pend    <= 1'b0;
    end else begin
      pend <= issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt     <= n_after;
            dropped <= dropped | !room;
            if (in_item.last) begin
              src   <= 1'b0;
              state <= (n_after > CNT_W'(1)) ? S_PRIME : S_EMIT;
            end
          end
        end
        S_PRIME: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (pass_done) begin
            src <= !src;
          end
          if (sort_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue && e_last) begin
            state   <= S_IDLE;
            cnt     <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    pend_last <= e_last;
    pend_ovf  <= dropped;
    if (state == S_IDLE) begin
      width <= CNT_W'(1);
      i     <= '0;
      k     <= '0;
      e     <= '0;
      mid   <= CNT_W'(1);
      j     <= CNT_W'(1);
      hi    <= (n_after > CNT_W'(2)) ? CNT_W'(2) : n_after;
    end else if (state == S_MERGE) begin
      i     <= i_m;
      j     <= j_m;
      k     <= seg_done ? new_lo : k1;
      width <= new_w;
      if (seg_done) begin
        mid <= mid_n;
        hi  <= hi_n;
      end
    end else if (issue) begin
      e <= e + CNT_W'(1);
    end
  end

endmodule

/* rtl/merge_sort_engine_unit.sv */
// Load: one cycle per input transaction; stall stays low until a last-marked one arrives.
// Sort: a priming state, then ceil(log2 N) merge passes over all N elements, one element
// written per cycle into the destination memory of the ping-pong pair.
// Emit: after the sort, one result per cycle through the output buffer while not stalled.
// Reset (synchronous, rst high) clears the sequencer, counts and output buffer; the
// memories are not cleared and only entries written in the current set are read.
module merge_sort_engine_unit
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ram_wr_t           wr_a;
  ram_wr_t           wr_b;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  logic [DATA_W-1:0] qa0;
  logic [DATA_W-1:0] qa1;
  logic [DATA_W-1:0] qb0;
  logic [DATA_W-1:0] qb1;
  logic [1:0]        credit;
  out_push_t         push;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .wr_a     (wr_a),
    .wr_b     (wr_b),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .qa0      (qa0),
    .qa1      (qa1),
    .qb0      (qb0),
    .qb1      (qb1),
    .credit   (credit),
    .push     (push)
  );

  mse_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_W)) u_ram_a (
    .clk    (clk),
    .we     (wr_a.we),
    .waddr  (wr_a.addr),
    .wdata  (wr_a.data),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (qa0),
    .rdata1 (qa1)
  );

  mse_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_W)) u_ram_b (
    .clk    (clk),
    .we     (wr_b.we),
    .waddr  (wr_b.addr),
    .wdata  (wr_b.data),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (qb0),
    .rdata1 (qb1)
  );

  mse_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .credit    (credit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/mse_checker.sv */
module mse_checker
  import mse_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic                     out_take;
  logic                     in_set;
  logic signed [DATA_W-1:0] prev_value;
  logic                     prev_ovf;

  assign out_take = out_valid && !out_stall;

  // track the previous result of the set being delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_set <= 1'b0;
    end else if (out_take) begin
      in_set <= !out_item.last_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      prev_value <= out_item.value_res;
      prev_ovf   <= out_item.overflow;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_sort_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.last) |=> in_stall)
    else $error("input not held off after closing transaction");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall, 2))
    else $error("result appeared without a sort in progress");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_take && in_set) |->
      ((out_item.value_res >= prev_value) && (out_item.overflow == prev_ovf)))
    else $error("results of a set out of order or overflow flag changed");

endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
